### rtl/lcr_pkg.sv
// ----------------------------------------------------------------------------
// lcr_pkg
// shared constants and codes for the load cell reader
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int DATA_BITS_DEF = 24;
  localparam int FIFO_DEPTH    = 4;

  localparam int DIV_W    = 16;
  localparam int GAIN_W   = 24;
  localparam int RAW_W    = 24;
  localparam int WEIGHT_W = 28;
  localparam int STATUS_W = 3;
  localparam int REQ_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_BITS = 16;

  localparam logic [DIV_W-1:0]    GAP_DIVISOR_RST = 16'd1400;
  localparam logic [GAIN_W-1:0]   GAIN_Q16_RST    = 24'd786215;
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX      = 28'hFFF_FFFF;

  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TARE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WEIGH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TARE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_WEIGHT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ABOVE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_GAP_DIVISOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q16    = 1'd1;

endpackage

### rtl/lcr_front.sv
// ----------------------------------------------------------------------------
// lcr_front
// per-tick serial pin sequencer, emits one record per tick
// ----------------------------------------------------------------------------
module lcr_front import lcr_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int REC_W = DATA_BITS + 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [REQ_W-1:0] in_req,
  input  logic             in_dout,
  output logic             rec_valid,
  input  logic             rec_ready,
  output logic [REC_W-1:0] rec_data
);

  localparam int BC_W = $clog2(DATA_BITS + 1);
  localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    PH_IDLE, PH_WAIT, PH_HIGH, PH_LOW, PH_XHIGH, PH_XLOW
  } phase_t;

  phase_t               phase, phase_next;
  logic [BC_W-1:0]      bit_count, bit_count_next;
  logic [DATA_BITS-1:0] shift_value, shift_value_next;
  logic                 pending_op, pending_op_next;
  logic                 sck, done;
  logic [DATA_BITS-1:0] code;
  logic                 fire;

  assign in_ready  = rec_ready;
  assign rec_valid = in_valid;
  assign fire      = in_valid && rec_ready;
  assign rec_data  = {code, pending_op, done, sck};

  always_comb begin
    phase_next       = phase;
    bit_count_next   = bit_count;
    shift_value_next = shift_value;
    pending_op_next  = pending_op;
    sck              = 1'b0;
    done             = 1'b0;
    code             = '0;
    unique case (phase)
      PH_IDLE: begin
        if (in_req == REQ_TARE || in_req == REQ_WEIGH) begin
          pending_op_next  = (in_req == REQ_WEIGH);
          bit_count_next   = '0;
          shift_value_next = '0;
          phase_next       = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!in_dout) begin
          phase_next = PH_HIGH;
        end
      end
      PH_HIGH: begin
        sck              = 1'b1;
        shift_value_next = {shift_value[DATA_BITS-2:0], 1'b0};
        phase_next       = PH_LOW;
      end
      PH_LOW: begin
        shift_value_next = {shift_value[DATA_BITS-1:1], in_dout};
        bit_count_next   = bit_count + 1'b1;
        phase_next       = (bit_count_next == BC_W'(DATA_BITS)) ? PH_XHIGH : PH_HIGH;
      end
      PH_XHIGH: begin
        sck        = 1'b1;
        phase_next = PH_XLOW;
      end
      PH_XLOW: begin
        done           = 1'b1;
        code           = shift_value ^ TOP_BIT;
        bit_count_next = '0;
        phase_next     = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bit_count   <= '0;
      shift_value <= '0;
      pending_op  <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      bit_count   <= bit_count_next;
      shift_value <= shift_value_next;
      pending_op  <= pending_op_next;
    end
  end

endmodule

### rtl/lcr_fifo.sv
// ----------------------------------------------------------------------------
// lcr_fifo
// small register queue between sequencer and result stage
// ----------------------------------------------------------------------------
module lcr_fifo import lcr_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0]      wr_ptr, rd_ptr;
  logic             full, empty;

  assign empty      = (wr_ptr == rd_ptr);
  assign full       = (wr_ptr[AW-1:0] == rd_ptr[AW-1:0]) && (wr_ptr[AW] != rd_ptr[AW]);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_data   = mem[rd_ptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      mem[wr_ptr[AW-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_valid && push_ready) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_valid && pop_ready) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) <= (AW+1)'(DEPTH))
    else $error("queue fill beyond depth");

endmodule

### rtl/lcr_div.sv
// ----------------------------------------------------------------------------
// lcr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lcr_div import lcr_pkg::*; #(
  parameter int NUM_W = 48,
  parameter int DEN_W = DIV_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             qbit;

  assign rem_sh  = {rem, num_r[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign qbit    = (rem_sh >= {1'b0, den_r});
  assign quot    = num_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(NUM_W);
        num_r <= num;
        den_r <= den;
        rem   <= '0;
      end else if (busy) begin
        num_r <= {num_r[NUM_W-2:0], qbit};
        rem   <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        cnt   <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");

endmodule

### rtl/lcr_back.sv
// ----------------------------------------------------------------------------
// lcr_back
// tare and weigh processing, config registers and output register
// ----------------------------------------------------------------------------
module lcr_back import lcr_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF,
  localparam int REC_W = DATA_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  output logic                  rec_ready,
  input  logic [REC_W-1:0]      rec_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic                  m_sck,
  output logic                  m_done,
  output logic [STATUS_W-1:0]   m_status,
  output logic [RAW_W-1:0]      m_raw,
  output logic [WEIGHT_W-1:0]   m_weight
);

  localparam int PROD_W = DATA_BITS + GAIN_W;
  localparam int QW     = PROD_W - FRAC_BITS;
  localparam int EXT_W  = QW + WEIGHT_W;
  localparam int CMP_W  = DATA_BITS + DIV_W + 1;

  typedef enum logic [1:0] {B_RUN, B_MUL, B_START, B_DIV} bstate_t;

  bstate_t              state;
  logic [DIV_W-1:0]     gap_divisor;
  logic [GAIN_W-1:0]    gain_q16;
  logic [DATA_BITS-1:0] tare_value;
  logic [WEIGHT_W-1:0]  last_weight;
  logic [DATA_BITS-1:0] diff_r;
  logic [DATA_BITS-1:0] code_r;
  logic [PROD_W-1:0]    prod;

  logic                 r_sck, r_done, r_weigh;
  logic [DATA_BITS-1:0] r_code;
  logic                 out_free, pop;
  logic [DATA_BITS:0]   diff_ext;
  logic [DATA_BITS-1:0] diff;
  logic                 above, over_thr;
  logic [DIV_W-1:0]     div_eff;
  logic                 div_start, div_done;
  logic [PROD_W-1:0]    quot;
  logic [EXT_W-1:0]     q_ext;
  logic [WEIGHT_W-1:0]  w_new;

  assign r_sck   = rec_data[0];
  assign r_done  = rec_data[1];
  assign r_weigh = rec_data[2];
  assign r_code  = rec_data[REC_W-1:3];

  assign out_free  = !m_valid || m_ready;
  assign rec_ready = (state == B_RUN) && out_free;
  assign pop       = rec_valid && rec_ready;

  assign diff_ext = {1'b0, r_code} - {1'b0, tare_value};
  assign diff     = diff_ext[DATA_BITS-1:0];
  assign above    = !diff_ext[DATA_BITS] && (diff != '0);
  assign div_eff  = (gap_divisor == '0) ? DIV_W'(1) : gap_divisor;
  assign over_thr = (CMP_W'({diff, 1'b0}) > CMP_W'(div_eff));

  assign div_start = (state == B_START);
  assign q_ext     = EXT_W'(quot[PROD_W-1:FRAC_BITS]);
  assign w_new     = (q_ext > EXT_W'(WEIGHT_MAX)) ? WEIGHT_MAX : q_ext[WEIGHT_W-1:0];

  lcr_div #(
    .NUM_W (PROD_W),
    .DEN_W (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (prod),
    .den   (div_eff),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_RUN;
      m_valid     <= 1'b0;
      gap_divisor <= GAP_DIVISOR_RST;
      gain_q16    <= GAIN_Q16_RST;
      tare_value  <= '0;
      last_weight <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GAP_DIVISOR: gap_divisor <= cfg_data[DIV_W-1:0];
          REG_GAIN_Q16:    gain_q16    <= cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        B_RUN: begin
          if (pop) begin
            m_sck  <= r_sck;
            m_done <= r_done;
            m_raw  <= r_done ? RAW_W'(r_code) : '0;
            if (!r_done) begin
              m_valid  <= 1'b1;
              m_status <= ST_NONE;
              m_weight <= last_weight;
            end else if (!r_weigh) begin
              m_valid    <= 1'b1;
              tare_value <= r_code;
              m_status   <= ST_TARE;
              m_weight   <= last_weight;
            end else if (!above) begin
              m_valid  <= 1'b1;
              m_status <= ST_NOT_ABOVE;
              m_weight <= last_weight;
            end else if (!over_thr) begin
              m_valid     <= 1'b1;
              last_weight <= '0;
              m_weight    <= '0;
              m_status    <= ST_CLEARED;
            end else begin
              m_valid <= 1'b0;
              diff_r  <= diff;
              code_r  <= r_code;
              state   <= B_MUL;
            end
          end else if (m_ready) begin
            m_valid <= 1'b0;
          end
        end
        B_MUL: begin
          prod  <= PROD_W'(diff_r) * PROD_W'(gain_q16);
          state <= B_START;
        end
        B_START: begin
          state <= B_DIV;
        end
        B_DIV: begin
          if (div_done) begin
            last_weight <= w_new;
            m_valid     <= 1'b1;
            m_sck       <= 1'b0;
            m_done      <= 1'b1;
            m_status    <= ST_WEIGHT;
            m_raw       <= RAW_W'(code_r);
            m_weight    <= w_new;
            state       <= B_RUN;
          end
        end
        default: begin
          state <= B_RUN;
        end
      endcase
    end
  end

  a_pop_needs_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> out_free)
    else $error("record taken while output register still full");

  a_div_end_room: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV && div_done) |-> !m_valid)
    else $error("weight ready while output register still full");

  a_plain_tick_out: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_done) |-> (m_status == ST_NONE && m_raw == '0))
    else $error("plain tick carries a status or code");

endmodule

### rtl/load_cell_adc_reader_tare_scale_top.sv
// ----------------------------------------------------------------------------
// load_cell_adc_reader_tare_scale_top
// tick-driven serial reader for a 24-bit load cell converter, with tare and
// scaling to a weight
//
// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    s_tuser req_type, s_tdata dout
// m_*       out  m_tvalid / m_tready    m_tuser done_res,status; m_tdata rest
// cfg_*     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one result per tick; ticks are taken one per cycle while the queue has room
// plain, tare and rejected weigh results leave in the cycle after their record is popped
// a scaled weigh result passes the multiply, divider start and bit-serial divide
// states in that order before it is registered
// a 4-entry queue absorbs ticks while the divider runs; m_tready low stalls
// only the result side until the queue fills
// synchronous reset, no clearing pass; config accepted every cycle
// ----------------------------------------------------------------------------
module load_cell_adc_reader_tare_scale_top import lcr_pkg::*; #(
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] dout
  input  logic [7:0]            s_tuser,   // [1:0] req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [55:0]           m_tdata,   // [0] sck, [24:1] raw_code, [52:25] weight
  output logic [7:0]            m_tuser,   // [0] done_res, [3:1] status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int REC_W = DATA_BITS + 3;

  logic             f_valid, f_ready;
  logic [REC_W-1:0] f_data;
  logic             q_valid, q_ready;
  logic [REC_W-1:0] q_data;

  logic                m_sck, m_done;
  logic [STATUS_W-1:0] m_status;
  logic [RAW_W-1:0]    m_raw;
  logic [WEIGHT_W-1:0] m_weight;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, m_weight, m_raw, m_sck};
  assign m_tuser   = {4'b0000, m_status, m_done};

  lcr_front #(
    .DATA_BITS (DATA_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser[REQ_W-1:0]),
    .in_dout   (s_tdata[0]),
    .rec_valid (f_valid),
    .rec_ready (f_ready),
    .rec_data  (f_data)
  );

  lcr_fifo #(
    .WIDTH (REC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lcr_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (q_valid),
    .rec_ready (q_ready),
    .rec_data  (q_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_sck     (m_sck),
    .m_done    (m_done),
    .m_status  (m_status),
    .m_raw     (m_raw),
    .m_weight  (m_weight)
  );

endmodule
